FILE: rtl/core/rrfb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rrfb_pkg
// Shared types and constants for the rotated-rectangle flatten blend unit.
// ----------------------------------------------------------------------------
package rrfb_pkg;

    localparam int ROT_FRAC    = 14;
    localparam int WEIGHT_FRAC = 16;
    localparam int DIV_W       = 31;               // extent / blend operand width
    localparam int T_W         = WEIGHT_FRAC + 1;  // quotient t in [0, 1.0]
    localparam int DIV_LAT     = T_W;              // one quotient bit per stage
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [16:0] WEIGHT_ONE = 17'd65536;
    localparam logic [15:0] COS_RESET  = 16'sd16384;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_DEPTH    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BLEND_DIST    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COS_ROT       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SIN_ROT       = 3'd7;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_z;
        logic signed [31:0] terrain_height;
    } item_t;

    typedef struct packed {
        logic               applies;
        logic signed [31:0] height_adjust;
        logic [16:0]        falloff_weight;
    } result_t;

    // per-item flags carried alongside the divider
    typedef struct packed {
        logic signed [32:0] diff;
        logic               hard_in;
        logic               outside;
        logic               zero_blend;
    } side_t;

endpackage : rrfb_pkg
`default_nettype wire

FILE: rtl/core/rrfb_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rrfb_div
// Pipelined restoring divider: t = (num << 16) / den for num <= den.
// ----------------------------------------------------------------------------
module rrfb_div (
    input  wire logic                       clk,
    input  wire logic [rrfb_pkg::DIV_W-1:0] num,
    input  wire logic [rrfb_pkg::DIV_W-1:0] den,
    output logic      [rrfb_pkg::T_W-1:0]   quo
);
    import rrfb_pkg::*;

    logic [DIV_W-1:0] rem_reg [DIV_LAT];
    logic [DIV_W-1:0] den_reg [DIV_LAT];
    logic [T_W-1:0]   q_reg   [DIV_LAT];

    // integer bit: num == den gives 1.0
    always_ff @(posedge clk)
    begin
        if (num >= den)
        begin
            rem_reg[0] <= num - den;
            q_reg[0]   <= T_W'(1);
        end
        else
        begin
            rem_reg[0] <= num;
            q_reg[0]   <= '0;
        end
        den_reg[0] <= den;
    end

    for (genvar i = 1; i < DIV_LAT; i++)
    begin : g_stage
        logic [DIV_W:0] r2;
        logic           ge;
        assign r2 = {rem_reg[i-1], 1'b0};
        assign ge = r2 >= {1'b0, den_reg[i-1]};
        always_ff @(posedge clk)
        begin
            if (ge)
                rem_reg[i] <= DIV_W'(r2 - {1'b0, den_reg[i-1]});
            else
                rem_reg[i] <= r2[DIV_W-1:0];
            q_reg[i]   <= {q_reg[i-1][T_W-2:0], ge};
            den_reg[i] <= den_reg[i-1];
        end
    end

    assign quo = q_reg[DIV_LAT-1];

endmodule : rrfb_div
`default_nettype wire

FILE: rtl/core/rotated_rect_flatten_blend_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rotated_rect_flatten_blend_unit
// Rotated-rectangle terrain flatten with smoothstep falloff, fully pipelined.
// ----------------------------------------------------------------------------
// Takes one sample per clock: busy is always low, so start is a transfer on
// every cycle it is high. The result comes out on result with done high for
// exactly one cycle; the receiver cannot stall it. The path from the start
// transfer to the result is the 17-stage bit-per-stage divider that forms
// the falloff fraction on each axis, plus four front stages
// (offset, rotate products, local frame, band distance) and four back stages
// (t squared, smoothstep, weight product, height delta with saturation).
// Configuration writes take effect at once and must only happen while no
// sample is in flight.
// ----------------------------------------------------------------------------
module rotated_rect_flatten_blend_unit (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // sample channel
    input  wire logic                             start,
    output logic                                  busy,
    input  wire rrfb_pkg::item_t                  item,
    // result channel
    output logic                                  done,
    output rrfb_pkg::result_t                     result,
    // configuration
    input  wire logic                             cfg_wr,
    input  wire logic [rrfb_pkg::CFG_IDX_W-1:0]   cfg_idx,
    input  wire logic [rrfb_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import rrfb_pkg::*;

    localparam int LAT = 4 + DIV_LAT + 4;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [31:0] center_x_reg, center_z_reg, target_reg;
    logic [DIV_W-1:0]   half_w_reg, half_d_reg, blend_reg;
    logic signed [15:0] cos_reg, sin_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_z_reg <= '0;
            target_reg   <= '0;
            half_w_reg   <= '0;
            half_d_reg   <= '0;
            blend_reg    <= '0;
            cos_reg      <= COS_RESET;
            sin_reg      <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_CENTER_X:      center_x_reg <= cfg_wdata;
                REG_CENTER_Z:      center_z_reg <= cfg_wdata;
                REG_TARGET_HEIGHT: target_reg   <= cfg_wdata;
                REG_HALF_WIDTH:    half_w_reg   <= cfg_wdata[DIV_W-1:0];
                REG_HALF_DEPTH:    half_d_reg   <= cfg_wdata[DIV_W-1:0];
                REG_BLEND_DIST:    blend_reg    <= cfg_wdata[DIV_W-1:0];
                REG_COS_ROT:       cos_reg      <= cfg_wdata[15:0];
                REG_SIN_ROT:       sin_reg      <= cfg_wdata[15:0];
                default:           ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Valid shift line, one bit per stage; the receiver never stalls
    // ------------------------------------------------------------------
    logic [LAT-1:0] valid_reg;
    logic           accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[LAT-2:0], accept};
    end

    // Stage A: offsets from the center and height error (33 bits, no wrap)
    logic signed [32:0] dx_reg, dz_reg, diff_a_reg;

    always_ff @(posedge clk)
    begin
        dx_reg     <= 33'(item.point_x) - 33'(center_x_reg);
        dz_reg     <= 33'(item.point_z) - 33'(center_z_reg);
        diff_a_reg <= 33'(target_reg) - 33'(item.terrain_height);
    end

    // Stage B: rotation products
    logic signed [48:0] xc_reg, zs_reg, zc_reg, xs_reg;
    logic signed [32:0] diff_b_reg;

    always_ff @(posedge clk)
    begin
        xc_reg     <= dx_reg * 49'(cos_reg);
        zs_reg     <= dz_reg * 49'(sin_reg);
        zc_reg     <= dz_reg * 49'(cos_reg);
        xs_reg     <= dx_reg * 49'(sin_reg);
        diff_b_reg <= diff_a_reg;
    end

    // Stage C: local frame (arithmetic shift is the floor) and magnitude
    logic signed [49:0] lx_sum, lz_sum;
    logic signed [35:0] lx, lz;
    logic [35:0]        ax_reg, az_reg;
    logic signed [32:0] diff_c_reg;

    assign lx_sum = 50'(xc_reg) + 50'(zs_reg);
    assign lz_sum = 50'(zc_reg) - 50'(xs_reg);
    assign lx     = lx_sum[49:ROT_FRAC];
    assign lz     = lz_sum[49:ROT_FRAC];

    always_ff @(posedge clk)
    begin
        ax_reg     <= lx[35] ? 36'(-lx) : 36'(lx);
        az_reg     <= lz[35] ? 36'(-lz) : 36'(lz);
        diff_c_reg <= diff_b_reg;
    end

    // Stage D: distance past the half extents, band test, divider numerators
    logic [35:0]      dist_x, dist_z, hw_ext, hd_ext, bd_ext;
    logic [DIV_W-1:0] num_x_reg, num_z_reg;
    side_t            side_d_reg;

    assign hw_ext = 36'(half_w_reg);
    assign hd_ext = 36'(half_d_reg);
    assign bd_ext = 36'(blend_reg);
    assign dist_x = (ax_reg > hw_ext) ? ax_reg - hw_ext : '0;
    assign dist_z = (az_reg > hd_ext) ? az_reg - hd_ext : '0;

    always_ff @(posedge clk)
    begin
        num_x_reg             <= blend_reg - dist_x[DIV_W-1:0];
        num_z_reg             <= blend_reg - dist_z[DIV_W-1:0];
        side_d_reg.diff       <= diff_c_reg;
        side_d_reg.hard_in    <= (ax_reg <= hw_ext) && (az_reg <= hd_ext);
        side_d_reg.outside    <= (dist_x > bd_ext) || (dist_z > bd_ext);
        side_d_reg.zero_blend <= (blend_reg == '0);
    end

    // Falloff fraction per axis; side data delayed to match
    logic [T_W-1:0] t_x, t_z;
    side_t          side_reg [DIV_LAT];

    rrfb_div u_div_x (.clk(clk), .num(num_x_reg), .den(blend_reg), .quo(t_x));
    rrfb_div u_div_z (.clk(clk), .num(num_z_reg), .den(blend_reg), .quo(t_z));

    always_ff @(posedge clk)
    begin
        side_reg[0] <= side_d_reg;
        for (int i = 1; i < DIV_LAT; i++)
            side_reg[i] <= side_reg[i-1];
    end

    // Stage E: t squared and the (3 - 2t) term
    logic [33:0] tt_x_reg, tt_z_reg;
    logic [17:0] k_x_reg, k_z_reg;
    side_t       side_e_reg;

    always_ff @(posedge clk)
    begin
        tt_x_reg   <= 34'(t_x) * 34'(t_x);
        tt_z_reg   <= 34'(t_z) * 34'(t_z);
        k_x_reg    <= 18'(3 * 65536) - {t_x, 1'b0};
        k_z_reg    <= 18'(3 * 65536) - {t_z, 1'b0};
        side_e_reg <= side_reg[DIV_LAT-1];
    end

    // Stage F: smoothstep per axis, Q1.16
    logic [51:0] sp_x, sp_z;
    logic [16:0] s_x_reg, s_z_reg;
    side_t       side_f_reg;

    assign sp_x = 52'(tt_x_reg) * 52'(k_x_reg);
    assign sp_z = 52'(tt_z_reg) * 52'(k_z_reg);

    always_ff @(posedge clk)
    begin
        s_x_reg    <= sp_x[48:32];
        s_z_reg    <= sp_z[48:32];
        side_f_reg <= side_e_reg;
    end

    // Stage G: combined weight, with hard edge and out-of-band selection
    logic [33:0]        wp;
    logic [16:0]        weight_next;
    logic [16:0]        weight_reg;
    logic signed [32:0] diff_g_reg;

    assign wp = 34'(s_x_reg) * 34'(s_z_reg);

    always_comb
    begin
        if (side_f_reg.zero_blend)
            weight_next = side_f_reg.hard_in ? WEIGHT_ONE : '0;
        else if (side_f_reg.outside)
            weight_next = '0;
        else
            weight_next = wp[32:16];
    end

    always_ff @(posedge clk)
    begin
        weight_reg <= weight_next;
        diff_g_reg <= side_f_reg.diff;
    end

    // Stage H: height delta, floor shift and saturation
    logic signed [50:0] dp;
    logic signed [34:0] dsh;
    logic signed [31:0] delta_sat;
    result_t            result_reg;

    assign dp  = 51'(diff_g_reg) * 51'($signed({1'b0, weight_reg}));
    assign dsh = dp[50:WEIGHT_FRAC];

    always_comb
    begin
        if (!dsh[34] && (dsh[33:31] != 3'b000))
            delta_sat = 32'sh7fff_ffff;
        else if (dsh[34] && (dsh[33:31] != 3'b111))
            delta_sat = 32'sh8000_0000;
        else
            delta_sat = dsh[31:0];
    end

    always_ff @(posedge clk)
    begin
        result_reg.applies        <= (weight_reg != '0);
        result_reg.height_adjust  <= (weight_reg != '0) ? delta_sat : '0;
        result_reg.falloff_weight <= weight_reg;
    end

    assign done   = valid_reg[LAT-1];
    assign result = result_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LAT))
        else $error("result strobe without matching sample transfer");

    a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.falloff_weight <= WEIGHT_ONE))
        else $error("blend weight above full strength");

    a_not_applied: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.applies) |-> (result.height_adjust == '0))
        else $error("height change given where flatten does not apply");

endmodule : rotated_rect_flatten_blend_unit
`default_nettype wire
